// ----- hw/rtl/tohm_pkg.sv -----
// ----------------------------------------------------------------------------
// tohm_pkg
// Shared types and constants of the time-ordered hit merger.
// ----------------------------------------------------------------------------
package tohm_pkg;

    localparam int LAYERS_DEF = 8;
    localparam int DEPTH_DEF  = 16;

    localparam int TIME_W = 40;
    localparam int EN_W   = 32;
    localparam int POS_W  = 16;
    localparam int LAY_W  = 4;

    localparam int IN_DATA_W  = 216;
    localparam int OUT_DATA_W = 168;

    localparam logic [TIME_W-1:0] ONE_SECOND_PS = 40'd1000000000000;

    // Configuration register indexes.
    localparam logic [1:0] REG_MERGE_WINDOW = 2'd0;
    localparam logic [1:0] REG_HIT_LIMIT    = 2'd1;
    localparam logic [1:0] REG_ENERGY_THR   = 2'd2;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_MERGED     = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_DROPPED    = 3'd2,
        ST_REJECTED   = 3'd3,
        ST_DRAINED    = 3'd4,
        ST_DRAIN_NONE = 3'd5
    } status_t;

    // One stored hit; position packed as z:y:x.
    typedef struct packed {
        logic [3*POS_W-1:0]  pos;
        logic [TIME_W-1:0]   t_entry;
        logic [TIME_W-1:0]   t_hit;
        logic [EN_W-1:0]     energy;
    } hit_t;

endpackage

// ----- hw/rtl/time_ordered_hit_merger.sv -----
// ----------------------------------------------------------------------------
// time_ordered_hit_merger
// Keeps one time-sorted hit list per layer in a single-port-read memory,
// merges deposits into nearby hits, inserts new ones and drains on request.
// ----------------------------------------------------------------------------
//  Channel  | Direction | tdata (low bit first)                        | tuser
//  s_       | in        | layer, energy, time_in, time_out, entry xyz,   | action
//           |           | exit xyz                                     |
//  m_       | out       | hit_layer, hit_energy, hit_time,             | status
//           |           | hit_entry_time, hit_x, hit_y, hit_z (tlast)  |
//  cfg_     | in        | cfg_index selects register, cfg_data value   | -
//
// A deposit scans the stored hits in turn and, on insert, moves the later entries
// up one place; scanned and moved entries add up to the layer count. The memory's
// one read port sets the pace. A drain reads every stored hit in turn and waits
// while the output stalls.
// Reset clears the layer counts and registers; the hit memory needs no clear.
// One request is worked on at a time; a full output register holds the block.
module time_ordered_hit_merger #(
    parameter int LAYERS = tohm_pkg::LAYERS_DEF,
    parameter int DEPTH  = tohm_pkg::DEPTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // layer, energy, time_in, time_out, entry_x/y/z, exit_x/y/z, zero pad
    input  logic [tohm_pkg::IN_DATA_W-1:0]      s_tdata,
    // action
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit_layer, hit_energy, hit_time, hit_entry_time, hit_x/y/z, zero pad
    output logic [tohm_pkg::OUT_DATA_W-1:0]     m_tdata,
    // status
    output logic [2:0]                          m_tuser,
    output logic                                m_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [39:0]                         cfg_data
);
    import tohm_pkg::*;

    localparam int ENTRIES = LAYERS * DEPTH;
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (LAYERS > 1) ? $clog2(LAYERS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_RD, S_CHK, S_MERGE, S_INS, S_SH_RD, S_SH_WR,
        S_INS_WR, S_DRN_RD, S_DRN_CHK, S_DRN_END
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [TIME_W-1:0] window_reg;
    logic [4:0]        limit_reg;
    logic [EN_W-1:0]   thr_reg;

    // Request held while it is worked on.
    logic              act_reg;
    logic [LAY_W-1:0]  lay_reg;
    logic [LW-1:0]     li_reg;
    hit_t              new_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     at_reg;
    hit_t              hold_reg;
    logic              hold_vld_reg;

    logic [CW-1:0]     count_reg [LAYERS];

    // Output register.
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [2:0]            m_tuser_reg;
    logic                  m_tlast_reg;

    // Hit memory.
    hit_t           mem [ENTRIES];
    hit_t           rdata_reg;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    hit_t           wr_data;

    function automatic logic [AW-1:0] addr_of(input logic [LW-1:0] li,
                                              input logic [CW-1:0] idx);
        return AW'(int'(li) * DEPTH + int'(idx));
    endfunction

    function automatic logic [OUT_DATA_W-1:0] pack_out(input logic [LAY_W-1:0] lay,
                                                       input hit_t h);
        return {4'd0, h.pos, h.t_entry, h.t_hit, h.energy, lay};
    endfunction

    // Input field unpacking and midpoint arithmetic.
    logic [TIME_W-1:0] in_tin, in_tout, in_tmid;
    logic [TIME_W:0]   in_tsum;
    logic [3*POS_W-1:0] in_pos;
    always_comb begin
        in_tin  = s_tdata[75:36];
        in_tout = s_tdata[115:76];
        in_tsum = {1'b0, in_tin} + {1'b0, in_tout};
        in_tmid = (in_tout > ONE_SECOND_PS) ? in_tin : in_tsum[TIME_W:1];
        for (int k = 0; k < 3; k++) begin
            logic [POS_W:0] ps;
            ps = {s_tdata[116 + 16*k + 15], s_tdata[116 + 16*k +: 16]}
               + {s_tdata[164 + 16*k + 15], s_tdata[164 + 16*k +: 16]};
            in_pos[16*k +: 16] = ps[POS_W:1];
        end
    end

    // Scan compare against the entry just read.
    logic [TIME_W-1:0] diff;
    logic              later, near;
    logic [EN_W:0]     esum;
    hit_t              merged;
    logic              reject, full, out_free;
    logic [7:0]        lim_eff;
    always_comb begin
        later  = rdata_reg.t_hit > new_reg.t_hit;
        diff   = later ? rdata_reg.t_hit - new_reg.t_hit : new_reg.t_hit - rdata_reg.t_hit;
        near   = diff < window_reg;
        esum   = {1'b0, rdata_reg.energy} + {1'b0, new_reg.energy};
        merged = rdata_reg;
        merged.energy = esum[EN_W] ? '1 : esum[EN_W-1:0];
        if (later) begin
            merged.t_hit   = new_reg.t_hit;
            merged.t_entry = new_reg.t_entry;
            merged.pos     = new_reg.pos;
        end
        lim_eff  = ({3'd0, limit_reg} > 8'(DEPTH)) ? 8'(DEPTH) : {3'd0, limit_reg};
        full     = 8'(cnt_reg) >= lim_eff;
        reject   = (lay_reg == '0) || (int'(lay_reg) > LAYERS)
                || (!act_reg && new_reg.energy == '0);
        out_free = !m_tvalid_reg || m_tready;
    end

    // A result enters the output register in this cycle.
    logic out_load;
    always_comb begin
        unique case (state_reg)
            S_PREP:                       out_load = out_free && reject;
            S_MERGE, S_INS_WR, S_DRN_END: out_load = out_free;
            S_INS:                        out_load = out_free && full;
            S_DRN_CHK: out_load = out_free && hold_vld_reg
                                  && (rdata_reg.energy > thr_reg);
            default:                      out_load = 1'b0;
        endcase
    end

    // Memory port control.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = addr_of(li_reg, idx_reg);
        wr_en   = 1'b0;
        wr_addr = addr_of(li_reg, idx_reg);
        wr_data = rdata_reg;
        unique case (state_reg)
            S_RD:      rd_en = (idx_reg != cnt_reg);
            S_DRN_RD:  rd_en = (idx_reg != cnt_reg);
            S_SH_RD: begin
                rd_en   = (idx_reg != at_reg);
                rd_addr = addr_of(li_reg, idx_reg - CW'(1));
            end
            S_SH_WR:   wr_en = 1'b1;
            S_MERGE: begin
                wr_en   = out_free;
                wr_data = merged;
            end
            S_INS_WR: begin
                wr_en   = out_free;
                wr_addr = addr_of(li_reg, at_reg);
                wr_data = new_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= 40'd10000;
            limit_reg  <= 5'd16;
            thr_reg    <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MERGE_WINDOW: window_reg <= cfg_data;
                REG_HIT_LIMIT:    limit_reg  <= cfg_data[4:0];
                REG_ENERGY_THR:   thr_reg    <= cfg_data[EN_W-1:0];
                default: ;
            endcase
        end
    end

    // Control sequencer and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            hold_vld_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            for (int k = 0; k < LAYERS; k++) begin
                count_reg[k] <= '0;
            end
        end else begin
            if (m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        act_reg         <= s_tuser;
                        lay_reg         <= s_tdata[3:0];
                        new_reg.energy  <= s_tdata[35:4];
                        new_reg.t_entry <= in_tin;
                        new_reg.t_hit   <= in_tmid;
                        new_reg.pos     <= in_pos;
                        state_reg       <= S_PREP;
                    end
                end
                S_PREP: begin
                    li_reg  <= LW'(lay_reg - LAY_W'(1));
                    cnt_reg <= count_reg[LW'(lay_reg - LAY_W'(1))];
                    idx_reg <= '0;
                    if (reject) begin
                        if (out_free) begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= pack_out(lay_reg, '0);
                            m_tuser_reg  <= ST_REJECTED;
                            m_tlast_reg  <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                    end else begin
                        state_reg <= act_reg ? S_DRN_RD : S_RD;
                    end
                end
                S_RD: begin
                    if (idx_reg == cnt_reg) begin
                        at_reg    <= cnt_reg;
                        state_reg <= S_INS;
                    end else begin
                        state_reg <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (near) begin
                        state_reg <= S_MERGE;
                    end else if (later) begin
                        at_reg    <= idx_reg;
                        state_reg <= S_INS;
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_RD;
                    end
                end
                S_MERGE: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= pack_out(lay_reg, merged);
                        m_tuser_reg  <= ST_MERGED;
                        m_tlast_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_INS: begin
                    if (full) begin
                        if (out_free) begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= pack_out(lay_reg, new_reg);
                            m_tuser_reg  <= ST_DROPPED;
                            m_tlast_reg  <= 1'b1;
                            state_reg    <= S_IDLE;
                        end
                    end else begin
                        idx_reg   <= cnt_reg;
                        state_reg <= S_SH_RD;
                    end
                end
                S_SH_RD: begin
                    state_reg <= (idx_reg == at_reg) ? S_INS_WR : S_SH_WR;
                end
                S_SH_WR: begin
                    idx_reg   <= idx_reg - CW'(1);
                    state_reg <= S_SH_RD;
                end
                S_INS_WR: begin
                    if (out_free) begin
                        count_reg[li_reg] <= cnt_reg + CW'(1);
                        m_tvalid_reg      <= 1'b1;
                        m_tdata_reg       <= pack_out(lay_reg, new_reg);
                        m_tuser_reg       <= ST_INSERTED;
                        m_tlast_reg       <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                end
                S_DRN_RD: begin
                    state_reg <= (idx_reg == cnt_reg) ? S_DRN_END : S_DRN_CHK;
                end
                S_DRN_CHK: begin
                    // A hit above threshold is held back until the next one is
                    // known, so the final report can carry tlast.
                    if (rdata_reg.energy > thr_reg) begin
                        if (!hold_vld_reg) begin
                            hold_reg     <= rdata_reg;
                            hold_vld_reg <= 1'b1;
                            idx_reg      <= idx_reg + CW'(1);
                            state_reg    <= S_DRN_RD;
                        end else if (out_free) begin
                            m_tvalid_reg <= 1'b1;
                            m_tdata_reg  <= pack_out(lay_reg, hold_reg);
                            m_tuser_reg  <= ST_DRAINED;
                            m_tlast_reg  <= 1'b0;
                            hold_reg     <= rdata_reg;
                            idx_reg      <= idx_reg + CW'(1);
                            state_reg    <= S_DRN_RD;
                        end
                    end else begin
                        idx_reg   <= idx_reg + CW'(1);
                        state_reg <= S_DRN_RD;
                    end
                end
                S_DRN_END: begin
                    if (out_free) begin
                        m_tvalid_reg      <= 1'b1;
                        m_tlast_reg       <= 1'b1;
                        count_reg[li_reg] <= '0;
                        hold_vld_reg      <= 1'b0;
                        state_reg         <= S_IDLE;
                        if (hold_vld_reg) begin
                            m_tdata_reg <= pack_out(lay_reg, hold_reg);
                            m_tuser_reg <= ST_DRAINED;
                        end else begin
                            m_tdata_reg <= pack_out(lay_reg, '0);
                            m_tuser_reg <= ST_DRAIN_NONE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;
    assign m_tlast   = m_tlast_reg;

`ifndef ASSERT_OFF
    // The memory is never written while the block waits for a request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg != S_IDLE)
        else $error("memory write while idle");

    // An accepted request closes the input until it is finished.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened during a request");

    // The working count never exceeds the list depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE && state_reg != S_PREP |-> int'(cnt_reg) <= DEPTH)
        else $error("layer count above depth");

    // A held drain hit exists only while a drain is in progress.
    assert property (@(posedge aclk) disable iff (!aresetn)
        hold_vld_reg |-> (state_reg == S_DRN_RD || state_reg == S_DRN_CHK
                          || state_reg == S_DRN_END))
        else $error("held hit outside drain");
`endif

endmodule
